// ===== design/cppd_pkg.sv =====
// Shared types and constants for the column-and-post picture decoder.
package cppd_pkg;

	localparam int LUMP_BYTES = 65536;
	localparam int LUMP_AW    = $clog2(LUMP_BYTES);
	localparam int MAX_DIM    = 1024;
	localparam int MAX_POSTS  = 64;
	localparam int POSTS_W    = $clog2(MAX_POSTS + 1);
	localparam int PAL_AW     = 8;
	localparam int RGB_W      = 24;

	localparam logic [7:0] POST_END = 8'hFF;
	localparam logic [3:0] OFFSET_TABLE_BASE = 4'd8;

	typedef enum logic [1:0] {
		REQ_LUMP_WR = 2'd0,
		REQ_PAL_WR  = 2'd1,
		REQ_READ    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OUTSIDE  = 2'd1,
		ST_PAST_BUF = 2'd2,
		ST_POST_CAP = 2'd3
	} status_t;

	// Which lump field a read feeds into the datapath.
	typedef enum logic [3:0] {
		LD_NONE, LD_W0, LD_W1, LD_H0, LD_H1,
		LD_O0, LD_O1, LD_O2, LD_O3, LD_TOP, LD_LEN, LD_PIX
	} load_t;

	// Lump read address source.
	typedef enum logic [2:0] {
		AS_CONST, AS_OFF, AS_POS, AS_POS1, AS_PIX
	} asel_t;

	typedef struct packed {
		logic       capture;   // latch input request
		logic       lump_we;
		logic       pal_we;
		logic       lump_re;
		asel_t      asel;
		logic [1:0] const_addr;
		load_t      load;
		logic       pos_from_off;
		logic       post_adv;
		logic       post_clr;
		logic       pal_re;
		logic       res_load;   // form the result
		status_t    res_status;
	} cmd_t;

	typedef struct packed {
		req_t    req;
		logic    dims_bad;
		logic    off_past;
		logic    pos_past;
		logic    pos1_past;
		logic    is_end;
		logic    cap_hit;
		logic    len_past;
		logic    covers;
	} sts_t;

endpackage

// ===== design/cppd_ram.sv =====
// Generic single-port RAM with registered read.
module cppd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end
endmodule

// ===== design/cppd_datapath.sv =====
// Datapath: lump and palette memories, walk registers and result register.
module cppd_datapath import cppd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  req_type,
	input  logic [15:0] byte_address,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_rgb,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	input  logic [7:0]  fill_byte_q,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        transparent,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [1:0]  status
);
	logic [1:0]         req_q;
	logic [15:0]        addr_q;
	logic [7:0]         val_q;
	logic [7:0]         pidx_q;
	logic [23:0]        rgb_q;
	logic [9:0]         x_q, y_q;
	logic [15:0]        w_q, h_q;
	logic [31:0]        pos_q;
	logic [7:0]         top_q, len_q, hit_idx_q;
	logic               hit_q;
	logic [POSTS_W-1:0] posts_q;
	logic [7:0]         lump_rd;
	logic [23:0]        pal_rd;
	logic [LUMP_AW-1:0] lump_addr;
	logic [31:0]        off_addr;
	logic [31:0]        pix_addr;
	logic [10:0]        dy;

	// capture request fields
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			addr_q <= byte_address;
			val_q  <= byte_value;
			pidx_q <= palette_index;
			rgb_q  <= palette_rgb;
			x_q    <= pixel_x;
			y_q    <= pixel_y;
		end
	end

	assign off_addr = 32'(OFFSET_TABLE_BASE) + {20'd0, x_q, 2'b00};
	assign dy       = {1'b0, y_q} - {3'd0, top_q};
	assign pix_addr = pos_q + 32'd3 + {21'd0, dy};

	// lump address select
	always_comb begin
		unique case (cmd.asel)
			AS_CONST: lump_addr = LUMP_AW'(cmd.const_addr);
			AS_OFF:   lump_addr = LUMP_AW'(off_addr + 32'(cmd.const_addr));
			AS_POS:   lump_addr = LUMP_AW'(pos_q);
			AS_POS1:  lump_addr = LUMP_AW'(pos_q + 32'd1);
			AS_PIX:   lump_addr = LUMP_AW'(pix_addr);
			default:  lump_addr = LUMP_AW'(addr_q);
		endcase
		if (cmd.lump_we) begin
			lump_addr = LUMP_AW'(addr_q);
		end
	end

	cppd_ram #(.WIDTH(8), .DEPTH(LUMP_BYTES)) u_lump (
		.clk(clk), .we(cmd.lump_we), .re(cmd.lump_re), .addr(lump_addr),
		.wdata(val_q), .rdata(lump_rd)
	);

	cppd_ram #(.WIDTH(RGB_W), .DEPTH(256)) u_pal (
		.clk(clk), .we(cmd.pal_we), .re(cmd.pal_re),
		.addr(cmd.pal_we ? pidx_q : hit_idx_q), .wdata(rgb_q), .rdata(pal_rd)
	);

	// loads from lump read data
	always_ff @(posedge clk) begin
		unique case (cmd.load)
			LD_W0:   w_q[7:0]    <= lump_rd;
			LD_W1:   w_q[15:8]   <= lump_rd;
			LD_H0:   h_q[7:0]    <= lump_rd;
			LD_H1:   h_q[15:8]   <= lump_rd;
			LD_O0:   pos_q[7:0]  <= lump_rd;
			LD_O1:   pos_q[15:8] <= lump_rd;
			LD_O2:   pos_q[23:16]<= lump_rd;
			LD_O3:   pos_q[31:24]<= lump_rd;
			LD_TOP:  top_q       <= lump_rd;
			LD_LEN:  len_q       <= lump_rd;
			LD_PIX:  hit_idx_q   <= lump_rd;
			default: ;
		endcase
		if (cmd.post_adv) begin
			pos_q <= pos_q + 32'd4 + {24'd0, len_q};
		end
	end

	// post counter and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posts_q <= '0;
			hit_q   <= 1'b0;
		end else if (cmd.post_clr) begin
			posts_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (cmd.load == LD_TOP) posts_q <= posts_q + 1'b1;
			if (cmd.load == LD_PIX) hit_q <= 1'b1;
		end
	end

	// status flags toward the controller
	always_comb begin
		sts.req       = req_t'(req_q);
		sts.dims_bad  = ($signed(w_q) <= 0) || ($signed(h_q) <= 0) ||
			($signed(w_q) > MAX_DIM) || ($signed(h_q) > MAX_DIM) ||
			({6'd0, x_q} >= w_q) || ({6'd0, y_q} >= h_q);
		sts.off_past  = (off_addr + 32'd3) >= 32'(LUMP_BYTES);
		sts.pos_past  = pos_q >= 32'(LUMP_BYTES);
		sts.pos1_past = (pos_q + 32'd1) >= 32'(LUMP_BYTES);
		sts.is_end    = lump_rd == POST_END;
		sts.cap_hit   = posts_q >= POSTS_W'(MAX_POSTS);
		sts.len_past  = (len_q != 8'd0) &&
			((pos_q + 32'd2 + {24'd0, len_q}) >= 32'(LUMP_BYTES));
		sts.covers    = ({1'b0, y_q} >= {3'd0, top_q}) &&
			({1'b0, y_q} < ({3'd0, top_q} + {3'd0, len_q}));
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status       <= cmd.res_status;
			image_width  <= (req_q == REQ_READ) ? w_q : 16'd0;
			image_height <= (req_q == REQ_READ) ? h_q : 16'd0;
			if (req_q == REQ_READ && cmd.res_status == ST_OK) begin
				if (hit_q) begin
					red   <= pal_rd[23:16];
					green <= pal_rd[15:8];
					blue  <= pal_rd[7:0];
					transparent <= 1'b0;
				end else begin
					red   <= fill_byte_q;
					green <= fill_byte_q;
					blue  <= fill_byte_q;
					transparent <= 1'b1;
				end
			end else begin
				red <= 8'd0; green <= 8'd0; blue <= 8'd0; transparent <= 1'b0;
			end
		end
	end
endmodule

// ===== design/cppd_ctrl.sv =====
// Controller state machine sequencing request capture, lump walk and result.
module cppd_ctrl import cppd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DISP  = 16'h0002,
		S_DIM   = 16'h0004,
		S_DCHK  = 16'h0008,
		S_OFF   = 16'h0010,
		S_TOPRD = 16'h0020,
		S_TOP   = 16'h0040,
		S_LEN   = 16'h0080,
		S_LCHK  = 16'h0100,
		S_PIX   = 16'h0200,
		S_PAL   = 16'h0400,
		S_RES   = 16'h0800,
		S_OUT   = 16'h1000
	} state_t;

	state_t    state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	status_t   st_q, st_d;

	assign in_stall = (state_q != S_IDLE) && !(state_q == S_OUT && !out_stall);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		st_d    = st_q;
		cmd     = '0;
		cmd.asel = AS_CONST;
		cmd.load = LD_NONE;
		cmd.res_status = st_q;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				st_d = ST_OK;
				cmd.post_clr = 1'b1;
				cnt_d = 3'd0;
				unique case (sts.req)
					REQ_LUMP_WR: begin cmd.lump_we = 1'b1; state_d = S_RES; end
					REQ_PAL_WR:  begin cmd.pal_we = 1'b1; state_d = S_RES; end
					REQ_READ:    begin
						cmd.lump_re = 1'b1; cmd.const_addr = 2'd0; state_d = S_DIM;
					end
					default:     state_d = S_RES;
				endcase
			end
			// read bytes 0..3 (read of n issued, data of n-1 loaded)
			S_DIM: begin
				cmd.load = load_t'(LD_W0 + cnt_q);
				if (cnt_q != 3'd3) begin
					cmd.lump_re = 1'b1;
					cmd.const_addr = 2'(cnt_q + 3'd1);
					cnt_d = cnt_q + 3'd1;
				end else begin
					state_d = S_DCHK;
				end
			end
			S_DCHK: begin
				cnt_d = 3'd0;
				if (sts.dims_bad) begin
					st_d = ST_OUTSIDE; state_d = S_RES;
				end else if (sts.off_past) begin
					st_d = ST_PAST_BUF; state_d = S_RES;
				end else begin
					cmd.lump_re = 1'b1; cmd.asel = AS_OFF; cmd.const_addr = 2'd0;
					state_d = S_OFF;
				end
			end
			S_OFF: begin
				cmd.load = load_t'(LD_O0 + cnt_q);
				if (cnt_q != 3'd3) begin
					cmd.lump_re = 1'b1; cmd.asel = AS_OFF;
					cmd.const_addr = 2'(cnt_q + 3'd1);
					cnt_d = cnt_q + 3'd1;
				end else begin
					state_d = S_TOPRD;
				end
			end
			S_TOPRD: begin
				if (sts.pos_past) begin
					st_d = ST_PAST_BUF; state_d = S_RES;
				end else begin
					cmd.lump_re = 1'b1; cmd.asel = AS_POS; state_d = S_TOP;
				end
			end
			S_TOP: begin
				if (sts.is_end) begin
					state_d = S_PAL;
				end else if (sts.cap_hit) begin
					st_d = ST_POST_CAP; state_d = S_RES;
				end else if (sts.pos1_past) begin
					cmd.load = LD_TOP; st_d = ST_PAST_BUF; state_d = S_RES;
				end else begin
					cmd.load = LD_TOP; cmd.lump_re = 1'b1; cmd.asel = AS_POS1;
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				cmd.load = LD_LEN; state_d = S_LCHK;
			end
			S_LCHK: begin
				if (sts.len_past) begin
					st_d = ST_PAST_BUF; state_d = S_RES;
				end else if (sts.covers) begin
					cmd.lump_re = 1'b1; cmd.asel = AS_PIX; state_d = S_PIX;
				end else begin
					cmd.post_adv = 1'b1; state_d = S_TOPRD;
				end
			end
			S_PIX: begin
				cmd.load = LD_PIX; cmd.post_adv = 1'b1; state_d = S_TOPRD;
			end
			S_PAL: begin
				cmd.pal_re = 1'b1; state_d = S_RES;
			end
			S_RES: begin
				cmd.res_load = 1'b1; state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (in_valid) begin
						cmd.capture = 1'b1; state_d = S_DISP;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			st_q    <= st_d;
		end
	end
endmodule

// ===== design/column_post_picture_decoder.sv =====
// Top level of the column-and-post picture decoder.
// Handles one request at a time. A pixel read walks the posts of the
// column (capped at 64 posts); most of its steps are accesses to the
// single-port lump memory, which sets the pace. Uncovered pixels return the
// fill byte with transparent set; nonzero status zeroes the color fields.
module column_post_picture_decoder import cppd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fill_byte_we,
	input  logic [7:0]  fill_byte_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] byte_address,
	input  logic [7:0]  byte_value,
	input  logic [7:0]  palette_index,
	input  logic [23:0] palette_rgb,
	input  logic [9:0]  pixel_x,
	input  logic [9:0]  pixel_y,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        transparent,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [1:0]  status
);
	cmd_t       cmd;
	sts_t       sts;
	logic [7:0] fill_byte_q;

	// fill byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fill_byte_q <= 8'd0;
		else if (fill_byte_we) fill_byte_q <= fill_byte_wdata;
	end

	cppd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	cppd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .byte_address(byte_address), .byte_value(byte_value),
		.palette_index(palette_index), .palette_rgb(palette_rgb),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .fill_byte_q(fill_byte_q),
		.red(red), .green(green), .blue(blue), .transparent(transparent),
		.image_width(image_width), .image_height(image_height), .status(status)
	);

	// error results carry no color
	a_err_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> red == 8'd0 && transparent == 1'b0)
		else $error("error result with color");

	// transparent pixels carry the fill byte
	a_transp_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && transparent |-> red == fill_byte_q && blue == fill_byte_q)
		else $error("transparent pixel without fill byte");

	// no request accepted while a result waits
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("request accepted during stalled result");
endmodule
